// File: design/mmbs_pkg.sv
// ----------------------------------------------------------------------------
// mmbs_pkg
// Shared types, constants and hash helpers for the multi-mode byte span engine.
// ----------------------------------------------------------------------------
package mmbs_pkg;

  localparam int COUNT_WIDTH = 48;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [31:0] CRC_POLY  = 32'h82F63B78;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

  // operating modes
  localparam logic [2:0] MODE_FNV   = 3'd0;
  localparam logic [2:0] MODE_XOR   = 3'd1;
  localparam logic [2:0] MODE_ADD   = 3'd2;
  localparam logic [2:0] MODE_COUNT = 3'd3;
  localparam logic [2:0] MODE_CRC   = 3'd4;
  localparam logic [2:0] MODE_FOLD  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_IMM  = 2'd1;
  localparam logic [1:0] REG_SEED = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       span_end;
    logic       job_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        job_done;
    logic [63:0] checksum;
    logic [47:0] touched_bytes;
    logic [31:0] span_total;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic hash_step;
    logic fold_step;
    logic cfg_we;
  } dp_cmd_t;

  // multiply by the fnv prime 2^40 + 2^8 + 0xb3 as shifts and adds
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    logic [63:0] low_part;
    low_part = (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    return (x << 40) + (x << 8) + low_part;
  endfunction

  // one reflected crc32c byte update
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] acc;
    acc = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : 32'd0);
    end
    return acc;
  endfunction

endpackage

// File: design/mmbs_ctrl.sv
// ----------------------------------------------------------------------------
// mmbs_ctrl
// Sequencer: accepts an item, steps it through the hash and fold phases and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module mmbs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  output mmbs_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HASH = 2'd1;
  localparam logic [1:0] ST_FOLD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       fold_go;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  assign accept  = in_valid && (state_r == ST_IDLE);
  // the result register must be free or draining this cycle
  assign fold_go = (state_r == ST_FOLD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HASH;
      end
      ST_HASH: state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (fold_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fold_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd.capture   = accept;
    cmd.hash_step = (state_r == ST_HASH);
    cmd.fold_step = fold_go;
    cmd.cfg_we    = cfg_valid && (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/mmbs_dp.sv
// ----------------------------------------------------------------------------
// mmbs_dp
// Datapath: configuration registers, job accumulators, span fold and the
// result register.
// ----------------------------------------------------------------------------
module mmbs_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mmbs_pkg::dp_cmd_t    cmd,
  input  mmbs_pkg::in_item_t   in_data,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  output mmbs_pkg::out_item_t  out_data
);

  localparam int CW = mmbs_pkg::COUNT_WIDTH;

  logic [2:0]  mode_r;
  logic [7:0]  imm_r;
  logic [63:0] seed_r;

  mmbs_pkg::in_item_t item_r;

  logic [63:0]   job_hash_r;
  logic [31:0]   crc_r;
  logic [CW-1:0] eq_count_r;
  logic [63:0]   span_hash_r;
  logic [63:0]   fold_r;
  logic [CW-1:0] byte_cnt_r;
  logic [31:0]   span_cnt_r;
  logic          job_open_r;

  mmbs_pkg::out_item_t out_r, out_nxt;

  logic [63:0] hash_base;
  logic        byte_counted;
  logic        span_done;
  logic [63:0] fold_nxt;
  logic [31:0] span_cnt_nxt;
  logic [63:0] sum;

  // first byte of a job starts from the seed
  assign hash_base = job_open_r ? job_hash_r : seed_r;
  assign span_done = item_r.span_end || item_r.job_end;

  always_comb begin
    case (mode_r) inside
      [mmbs_pkg::MODE_FNV:mmbs_pkg::MODE_FOLD]: byte_counted = 1'b1;
      default:                                   byte_counted = 1'b0;
    endcase
  end

  assign fold_nxt     = span_done ?
                        (fold_r ^ mmbs_pkg::fnv_mul(span_hash_r ^ {56'd0, imm_r})) : fold_r;
  assign span_cnt_nxt = (span_done && !(&span_cnt_r)) ? span_cnt_r + 32'd1 : span_cnt_r;

  always_comb begin
    sum = 64'd0;
    if (item_r.job_end) begin
      case (mode_r)
        mmbs_pkg::MODE_FNV:   sum = job_hash_r;
        mmbs_pkg::MODE_COUNT: sum = 64'(eq_count_r);
        mmbs_pkg::MODE_CRC:   sum = {32'd0, ~crc_r};
        mmbs_pkg::MODE_FOLD:  sum = fold_nxt;
        default:              sum = 64'd0;
      endcase
    end
  end

  always_comb begin
    out_nxt.out_byte = item_r.data_byte;
    case (mode_r)
      mmbs_pkg::MODE_XOR: out_nxt.out_byte = item_r.data_byte ^ imm_r;
      mmbs_pkg::MODE_ADD: out_nxt.out_byte = item_r.data_byte + imm_r;
      default:            out_nxt.out_byte = item_r.data_byte;
    endcase
    out_nxt.job_done      = item_r.job_end;
    out_nxt.checksum      = sum;
    out_nxt.touched_bytes = 48'(byte_cnt_r);
    out_nxt.span_total    = span_cnt_nxt;
  end

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.fold_step) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mmbs_pkg::MODE_FNV;
      imm_r  <= 8'd0;
      seed_r <= mmbs_pkg::FNV_BASIS;
    end else if (cmd.cfg_we) begin
      case (cfg_index)
        mmbs_pkg::REG_MODE: mode_r <= cfg_data[2:0];
        mmbs_pkg::REG_IMM:  imm_r  <= cfg_data[7:0];
        mmbs_pkg::REG_SEED: seed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_hash_r  <= mmbs_pkg::FNV_BASIS;
      crc_r       <= mmbs_pkg::CRC_INIT;
      eq_count_r  <= '0;
      span_hash_r <= mmbs_pkg::FNV_BASIS;
      fold_r      <= 64'd0;
      byte_cnt_r  <= '0;
      span_cnt_r  <= 32'd0;
      job_open_r  <= 1'b0;
    end else if (cmd.hash_step) begin
      job_hash_r  <= mmbs_pkg::fnv_mul(hash_base ^ {56'd0, item_r.data_byte});
      crc_r       <= mmbs_pkg::crc_byte(crc_r, item_r.data_byte);
      span_hash_r <= mmbs_pkg::fnv_mul(span_hash_r ^ {56'd0, item_r.data_byte});
      job_open_r  <= 1'b1;
      if (item_r.data_byte == imm_r && !(&eq_count_r)) eq_count_r <= eq_count_r + CW'(1);
      if (byte_counted && !(&byte_cnt_r)) byte_cnt_r <= byte_cnt_r + CW'(1);
    end else if (cmd.fold_step) begin
      if (item_r.job_end) begin
        // job finished: back to start values
        job_hash_r  <= seed_r;
        crc_r       <= mmbs_pkg::CRC_INIT;
        eq_count_r  <= '0;
        span_hash_r <= mmbs_pkg::FNV_BASIS;
        fold_r      <= 64'd0;
        byte_cnt_r  <= '0;
        span_cnt_r  <= 32'd0;
        job_open_r  <= 1'b0;
      end else begin
        fold_r     <= fold_nxt;
        span_cnt_r <= span_cnt_nxt;
        if (span_done) span_hash_r <= mmbs_pkg::FNV_BASIS;
      end
    end
  end

endmodule

// File: design/multi_mode_byte_span_engine_core.sv
// Sequence: an accepted item passes the hash and then the fold state before out_valid
// rises, and the fold waits while out_stall holds a full result register. Items go
// one at a time through the controller's three-phase sequence around the fnv
// shift-add multipliers, and in_stall is high until the item has folded.
// Reset: synchronous active-low rst_n clears the sequencer, result valid,
// configuration registers and job accumulators to their start values.
// ----------------------------------------------------------------------------
// multi_mode_byte_span_engine_core
// Top level: byte stream engine with fnv-1a 64, xor, add, count, crc32c and
// span hash fold modes.
// ----------------------------------------------------------------------------
module multi_mode_byte_span_engine_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mmbs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mmbs_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data
);

  mmbs_pkg::dp_cmd_t cmd;

  mmbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  mmbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// File: design/mmbs_checker.sv
// ----------------------------------------------------------------------------
// mmbs_checker
// Port-level checks on the byte span engine, bound to the top level.
// ----------------------------------------------------------------------------
module mmbs_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input mmbs_pkg::out_item_t  out_data
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  a_sum_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.job_done || out_data.checksum == 64'd0))
    else $error("checksum nonzero before job end");

  a_span_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.job_done |-> out_data.span_total != 32'd0)
    else $error("job ended with no span counted");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multi_mode_byte_span_engine_core mmbs_checker u_mmbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: dv/tb_multi_mode_byte_span_engine_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_mode_byte_span_engine_core
// Self-checking bench for the byte span engine. Items go in over the stall
// handshake and a behavioural predictor follows every accepted byte. Each
// result is checked field by field against the oldest prediction. The bench
// covers every mode, including the two undefined ones, changes of mode and
// seed in the middle of a job, and long random jobs with random gaps and
// output stalls. It also holds the output off for a long stretch so that the
// engine backs up onto its input.
// ----------------------------------------------------------------------------
module tb_multi_mode_byte_span_engine_core;

  localparam logic [63:0] FNV_PRIME   = 64'd1099511628211;
  localparam logic [2:0]  MODE_SPARE6 = 3'd6;
  localparam logic [2:0]  MODE_SPARE7 = 3'd7;
  localparam logic [1:0]  REG_SPARE   = 2'd3;
  localparam logic [mmbs_pkg::COUNT_WIDTH-1:0] COUNT_FULL = '1;
  localparam int STALL_PCT = 17;
  localparam int HOLD_CYCLES = 80;
  localparam int PRINT_CAP = 30;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mmbs_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mmbs_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = mmbs_pkg::REG_MODE;
  logic [63:0]         cfg_data = '0;

  multi_mode_byte_span_engine_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor copy of the registers and job accumulators
  logic [2:0]                       cur_mode;
  logic [7:0]                       cur_imm;
  logic [63:0]                      cur_seed;
  logic [63:0]                      job_fnv;
  logic [31:0]                      crc_reg;
  logic [mmbs_pkg::COUNT_WIDTH-1:0] match_count;
  logic [63:0]                      span_fnv;
  logic [63:0]                      span_fold;
  logic [mmbs_pkg::COUNT_WIDTH-1:0] byte_count;
  logic [31:0]                      span_count;
  logic                             in_job;

  mmbs_pkg::out_item_t pending_results[$];
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("tb_multi_mode_byte_span_engine_core NOT OK");
    $finish;
  end

  function automatic void clear_job();
    job_fnv     = cur_seed;
    crc_reg     = mmbs_pkg::CRC_INIT;
    match_count = '0;
    span_fnv    = mmbs_pkg::FNV_BASIS;
    span_fold   = '0;
    byte_count  = '0;
    span_count  = '0;
    in_job      = 1'b0;
  endfunction

  function automatic mmbs_pkg::out_item_t step_byte_engine(input mmbs_pkg::in_item_t it);
    mmbs_pkg::out_item_t r;
    logic [7:0]          b;
    b = it.data_byte;
    r = '0;
    if (!in_job) begin
      job_fnv = cur_seed;
      in_job  = 1'b1;
    end
    // the fnv and crc accumulators and the match count see every byte, whatever the mode
    job_fnv = (job_fnv ^ {56'd0, b}) * FNV_PRIME;
    crc_reg = crc_reg ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      crc_reg = crc_reg[0] ? ((crc_reg >> 1) ^ mmbs_pkg::CRC_POLY) : (crc_reg >> 1);
    end
    if (b == cur_imm && match_count != COUNT_FULL) match_count++;
    span_fnv = (span_fnv ^ {56'd0, b}) * FNV_PRIME;

    case (cur_mode)
      mmbs_pkg::MODE_XOR: r.out_byte = b ^ cur_imm;
      mmbs_pkg::MODE_ADD: r.out_byte = b + cur_imm;
      default:            r.out_byte = b;
    endcase
    // undefined modes leave the byte count alone
    if (cur_mode <= mmbs_pkg::MODE_FOLD && byte_count != COUNT_FULL) byte_count++;

    if (it.span_end || it.job_end) begin
      span_fold ^= (span_fnv ^ {56'd0, cur_imm}) * FNV_PRIME;
      span_fnv = mmbs_pkg::FNV_BASIS;
      if (span_count != '1) span_count++;
    end

    if (it.job_end) begin
      case (cur_mode)
        mmbs_pkg::MODE_FNV:   r.checksum = job_fnv;
        mmbs_pkg::MODE_COUNT: r.checksum = 64'(match_count);
        mmbs_pkg::MODE_CRC:   r.checksum = {32'd0, ~crc_reg};
        mmbs_pkg::MODE_FOLD:  r.checksum = span_fold;
        default:              r.checksum = '0;
      endcase
    end
    r.job_done      = it.job_end;
    r.touched_bytes = 48'(byte_count);
    r.span_total    = span_count;
    if (it.job_end) clear_job();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    // later mismatches are only counted, to keep the log short
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  // checks each result, then predicts for the item taken at the same edge
  always @(posedge clk) begin
    mmbs_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item outstanding", '0, out_data.checksum);
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", want.out_byte, out_data.out_byte);
          if (out_data.job_done !== want.job_done)
            report_mismatch("job_done", want.job_done, out_data.job_done);
          if (out_data.checksum !== want.checksum)
            report_mismatch("checksum", want.checksum, out_data.checksum);
          if (out_data.touched_bytes !== want.touched_bytes)
            report_mismatch("touched_bytes", want.touched_bytes, out_data.touched_bytes);
          if (out_data.span_total !== want.span_total)
            report_mismatch("span_total", want.span_total, out_data.span_total);
        end
      end
      if (in_valid && !in_stall) pending_results.push_back(step_byte_engine(in_data));
    end
  end

  // receiver: random stalls, or a long counted hold when asked for
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < STALL_PCT);
    end
  end

  function automatic mmbs_pkg::in_item_t mk_item(input logic [7:0] b, input logic s_end,
                                                 input logic j_end);
    mmbs_pkg::in_item_t it;
    it.data_byte = b;
    it.span_end  = s_end;
    it.job_end   = j_end;
    return it;
  endfunction

  function automatic mmbs_pkg::in_item_t random_item();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 25) b = cur_imm;
    else if (pick < 30) b = 8'h00;
    else if (pick < 35) b = 8'hFF;
    else b = 8'($urandom);
    return mk_item(b, $urandom_range(99) < 30, $urandom_range(99) < 10);
  endfunction

  task automatic send_item(input mmbs_pkg::in_item_t it);
    if (idle_on && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic stop_items();
    in_valid <= 1'b0;
  endtask

  // every result back means the engine holds nothing
  task automatic wait_idle();
    while (results_seen != items_sent) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra step
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mmbs_pkg::REG_MODE: cur_mode = val[2:0];
      mmbs_pkg::REG_IMM:  cur_imm  = val[7:0];
      mmbs_pkg::REG_SEED: cur_seed = val;
      default: ;
    endcase
  endtask

  task automatic end_config();
    cfg_valid <= 1'b0;
  endtask

  task automatic test_each_mode();
    logic [2:0] all_modes [8];
    logic [7:0] imm;
    all_modes = '{mmbs_pkg::MODE_FNV, mmbs_pkg::MODE_XOR, mmbs_pkg::MODE_ADD,
                  mmbs_pkg::MODE_COUNT, mmbs_pkg::MODE_CRC, mmbs_pkg::MODE_FOLD,
                  MODE_SPARE6, MODE_SPARE7};
    foreach (all_modes[i]) begin
      imm = i[0] ? 8'hFF : 8'h00;
      wait_idle();
      // the first job runs on the reset settings
      if (i != 0) begin
        write_reg(mmbs_pkg::REG_MODE, {61'd0, all_modes[i]});
        write_reg(mmbs_pkg::REG_IMM, {56'd0, imm});
        end_config();
      end
      send_item(mk_item(imm, 1'b1, 1'b0));
      // job end with no span end closes the span as well
      send_item(mk_item(~imm, 1'b0, 1'b1));
      stop_items();
    end
  endtask

  task automatic test_mid_job_config();
    wait_idle();
    write_reg(mmbs_pkg::REG_MODE, {61'd0, mmbs_pkg::MODE_FNV});
    write_reg(mmbs_pkg::REG_SEED, 64'h0123_4567_89AB_CDEF);
    write_reg(mmbs_pkg::REG_IMM, 64'h5A);
    end_config();
    send_item(mk_item(8'h5A, 1'b0, 1'b0));
    send_item(mk_item(8'h11, 1'b1, 1'b0));
    stop_items();
    // new seed waits for the next job, mode and immediate apply at once
    wait_idle();
    write_reg(mmbs_pkg::REG_MODE, {61'd0, mmbs_pkg::MODE_CRC});
    write_reg(mmbs_pkg::REG_SEED, 64'd0);
    write_reg(mmbs_pkg::REG_IMM, 64'h11);
    end_config();
    send_item(mk_item(8'h11, 1'b0, 1'b0));
    send_item(mk_item(8'h80, 1'b0, 1'b1));
    stop_items();
    wait_idle();
    write_reg(mmbs_pkg::REG_MODE, {61'd0, mmbs_pkg::MODE_FOLD});
    end_config();
    send_item(mk_item(8'h00, 1'b1, 1'b0));
    stop_items();
    wait_idle();
    write_reg(mmbs_pkg::REG_MODE, {61'd0, mmbs_pkg::MODE_FNV});
    end_config();
    send_item(mk_item(8'hFF, 1'b1, 1'b1));
    send_item(mk_item(8'h42, 1'b0, 1'b1));
    stop_items();
  endtask

  task automatic random_config();
    int pick;
    if ($urandom_range(99) < 60) begin
      pick = $urandom_range(99);
      write_reg(mmbs_pkg::REG_MODE,
                (pick < 8) ? 64'($urandom_range(7, 6)) : 64'($urandom_range(5, 0)));
    end
    if ($urandom_range(99) < 60) begin
      pick = $urandom_range(99);
      write_reg(mmbs_pkg::REG_IMM,
                (pick < 20) ? 64'h00 : (pick < 40) ? 64'hFF : 64'($urandom_range(255)));
    end
    if ($urandom_range(99) < 50) begin
      pick = $urandom_range(99);
      write_reg(mmbs_pkg::REG_SEED, (pick < 15) ? 64'd0 : (pick < 30) ? '1 :
                (pick < 45) ? mmbs_pkg::FNV_BASIS : {$urandom, $urandom});
    end
    // the unused index must change nothing
    if ($urandom_range(99) < 5) write_reg(REG_SPARE, {$urandom, $urandom});
    end_config();
  endtask

  task automatic test_back_to_back();
    wait_idle();
    idle_on = 1'b0;
    random_config();
    repeat (150) send_item(random_item());
    stop_items();
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    wait_idle();
    random_config();
    hold_req = 1'b1;
    repeat (60) send_item(random_item());
    stop_items();
  endtask

  task automatic test_random_jobs(input int n_items);
    int sent;
    int chunk;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      random_config();
      chunk = $urandom_range(70, 20);
      repeat (chunk) send_item(random_item());
      stop_items();
      sent += chunk;
    end
  endtask

  initial begin
    cur_mode = mmbs_pkg::MODE_FNV;
    cur_imm  = 8'h00;
    cur_seed = mmbs_pkg::FNV_BASIS;
    clear_job();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_each_mode();
    test_mid_job_config();
    test_back_to_back();
    test_output_hold();
    test_random_jobs(1620);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_multi_mode_byte_span_engine_core OK");
    end else begin
      $display("tb_multi_mode_byte_span_engine_core NOT OK");
    end
    $finish;
  end

endmodule
